### hdl/ntt_pkg.sv
// shared types and constants for the modular convolution block
// no dependencies
`timescale 1ns / 1ps

package ntt_pkg;

  localparam int COEFF_W = 30;
  localparam int LEN_W   = 6;
  localparam int DEF_LOG_MAX_N   = 6;
  localparam int DEF_MAX_SEQ_LEN = 32;
  localparam int HARD_CAP        = 32;

  localparam logic [COEFF_W-1:0] PRIME = 30'd1004535809;

  typedef logic [COEFF_W-1:0] coeff_t;
  typedef logic [LEN_W-1:0]   len_t;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MUL    = 2'd2,
    OP_SQR    = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e opcode;
    coeff_t  coeff;
  } in_word_t;

  typedef struct packed {
    coeff_t result_coeff;
    len_t   result_index;
    logic   last;
  } out_word_t;

  typedef struct packed {
    logic   start;
    coeff_t x;
    coeff_t y;
  } mm_req_t;

  typedef struct packed {
    logic   done;
    coeff_t prod;
  } mm_rsp_t;

  function automatic coeff_t add_mod(input coeff_t a, input coeff_t b);
    logic [COEFF_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[COEFF_W-1:0];
  endfunction

endpackage

### hdl/ntt_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ntt_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

### hdl/ntt_modmul.sv
// bit-serial modular multiplier, one bit of x per cycle, msb first
// depends on ntt_pkg
`timescale 1ns / 1ps

module ntt_modmul
  import ntt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mm_req_t req_i,
  output mm_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(COEFF_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  coeff_t           x_q, x_d, y_q, y_d, r_q, r_d;
  logic             done_q, done_d;
  logic [COEFF_W:0] dbl;
  coeff_t           dbl_m;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    r_d    = r_q;
    done_d = 1'b0;
    dbl    = {r_q, 1'b0};
    dbl_m  = (dbl >= {1'b0, PRIME}) ? coeff_t'(dbl - {1'b0, PRIME}) : dbl[COEFF_W-1:0];
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = req_i.x;
      y_d    = req_i.y;
      r_d    = '0;
    end else if (busy_q) begin
      r_d = add_mod(dbl_m, x_q[COEFF_W-1] ? y_q : '0);
      x_d = {x_q[COEFF_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(COEFF_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    r_q <= r_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = r_q;

endmodule

### hdl/ntt_polynomial_convolution.sv
// channel   dir  handshake                 word
// in        in   in_valid_i / in_stall_o   in_word_i  (opcode, coeff)
// out       out  out_valid_o / out_stall_i out_word_o (result_coeff, result_index, last)
//
// loads are written straight into the coefficient rams; a multiply or square walks every
// partial product through one bit-serial modular multiplier, so its run time grows with
// the product of the two operand lengths and with output stalls
// in_stall_o is high from a compute command until its last word is registered out
// reset clears lengths and control; coefficient rams are not cleared
// top level of the modular convolution block, depends on ntt_pkg, ntt_ram, ntt_modmul
`timescale 1ns / 1ps

module ntt_polynomial_convolution
  import ntt_pkg::*;
#(
  parameter int LOG_MAX_N   = DEF_LOG_MAX_N,
  parameter int MAX_SEQ_LEN = DEF_MAX_SEQ_LEN
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int HALF_N = 1 << (LOG_MAX_N - 1);
  localparam int CAP_A  = (MAX_SEQ_LEN < HALF_N) ? MAX_SEQ_LEN : HALF_N;
  localparam int CAP    = (CAP_A < HARD_CAP) ? CAP_A : HARD_CAP;
  localparam int AW     = (CAP > 1) ? $clog2(CAP) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ITEM = 7'b0000010,
    S_RD   = 7'b0000100,
    S_WAIT = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e    state_q, state_d;
  len_t      len_a_q, len_a_d, len_b_q, len_b_d;
  len_t      nx_q, nx_d, ny_q, ny_d, total_q, total_d;
  len_t      k_q, k_d, i_q, i_d, hi_q, hi_d;
  logic      sq_q, sq_d;
  coeff_t    acc_q, acc_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic      accept, wr_a, wr_b, slot_free;
  coeff_t    c_red, rd_a, rd_a2, rd_b;
  len_t      kmi;
  mm_req_t   mm_req;
  mm_rsp_t   mm_rsp;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign c_red = (in_word_i.coeff >= PRIME) ? (in_word_i.coeff - PRIME) : in_word_i.coeff;
  assign wr_a = accept && (in_word_i.opcode == OP_LOAD_A) && (len_a_q < LEN_W'(CAP));
  assign wr_b = accept && (in_word_i.opcode == OP_LOAD_B) && (len_b_q < LEN_W'(CAP));
  assign kmi  = k_q - i_q;

  ntt_ram #(.WIDTH(COEFF_W), .DEPTH(CAP), .AW(AW)) u_ram_a (
    .clk_i, .wr_en_i(wr_a), .wr_addr_i(len_a_q[AW-1:0]), .wr_data_i(c_red),
    .rd_addr_i(i_q[AW-1:0]), .rd_data_o(rd_a)
  );

  ntt_ram #(.WIDTH(COEFF_W), .DEPTH(CAP), .AW(AW)) u_ram_a2 (
    .clk_i, .wr_en_i(wr_a), .wr_addr_i(len_a_q[AW-1:0]), .wr_data_i(c_red),
    .rd_addr_i(kmi[AW-1:0]), .rd_data_o(rd_a2)
  );

  ntt_ram #(.WIDTH(COEFF_W), .DEPTH(CAP), .AW(AW)) u_ram_b (
    .clk_i, .wr_en_i(wr_b), .wr_addr_i(len_b_q[AW-1:0]), .wr_data_i(c_red),
    .rd_addr_i(kmi[AW-1:0]), .rd_data_o(rd_b)
  );

  assign mm_req.start = (state_q == S_WAIT);
  assign mm_req.x     = rd_a;
  assign mm_req.y     = sq_q ? rd_a2 : rd_b;

  ntt_modmul u_modmul (
    .clk_i, .rst_ni, .req_i(mm_req), .rsp_o(mm_rsp)
  );

  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    total_d     = total_q;
    k_d         = k_q;
    i_d         = i_q;
    hi_d        = hi_q;
    sq_d        = sq_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (wr_a) len_a_d = len_a_q + 1'b1;
        if (wr_b) len_b_d = len_b_q + 1'b1;
        if (accept && (in_word_i.opcode == OP_MUL || in_word_i.opcode == OP_SQR)) begin
          sq_d    = (in_word_i.opcode == OP_SQR);
          nx_d    = len_a_q;
          ny_d    = sq_d ? len_a_q : len_b_q;
          len_a_d = '0;
          len_b_d = '0;
          k_d     = '0;
          acc_d   = '0;
          if (nx_d == '0 || ny_d == '0) begin
            total_d = LEN_W'(1);
            state_d = S_EMIT;
          end else begin
            total_d = nx_d + ny_d - 1'b1;
            state_d = S_ITEM;
          end
        end
      end
      S_ITEM: begin
        acc_d   = '0;
        i_d     = (k_q >= ny_q) ? (k_q - ny_q + 1'b1) : '0;
        hi_d    = (k_q < nx_q) ? k_q : (nx_q - 1'b1);
        state_d = S_RD;
      end
      S_RD:   state_d = S_WAIT;
      S_WAIT: state_d = S_MUL;
      S_MUL: begin
        if (mm_rsp.done) state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = add_mod(acc_q, mm_rsp.prod);
        if (i_q == hi_q) begin
          state_d = S_EMIT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.result_coeff = acc_q;
          out_d.result_index = k_q;
          out_d.last         = (k_q == total_q - 1'b1);
          if (out_d.last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_ITEM;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_a_q     <= len_a_d;
      len_b_q     <= len_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q    <= nx_d;
    ny_q    <= ny_d;
    total_q <= total_d;
    k_q     <= k_d;
    i_q     <= i_d;
    hi_q    <= hi_d;
    sq_q    <= sq_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> state_q == S_MUL) else $error("multiplier done outside mul state");
  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.result_coeff < PRIME) else $error("result not reduced");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !accept) else $error("word accepted while busy");
`endif

endmodule
